### rtl/hpe_pkg.sv
// Shared types and the static Huffman code table for the HPACK string encoder.
// Used by hpe_packer, hpe_serializer and hpack_huffman_encoder; no dependencies.
package hpe_pkg;

    localparam int MaxCodeBits = 30;
    localparam int GroupBytes  = 5;

    // Bytes completed by one octet, handed from the packer to the serializer
    typedef struct packed {
        logic [GroupBytes-1:0][7:0] bytes;  // byte 0 goes out first
        logic [2:0]                 cnt;    // 1..5 bytes valid
        logic                       last;   // final byte closes the string
        logic [2:0]                 pad;    // one bits padded into the final byte
    } t_group;

    localparam logic [MaxCodeBits-1:0] CodeWord [256] = '{
        30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,
        30'hfffffe7,30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,
        30'hfffffeb,30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,
        30'hffffff2,30'h3ffffffe,30'hffffff3,30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,
        30'hffffff8,30'hffffff9,30'hffffffa,30'hffffffb,
        30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
        30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
        30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
        30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
        30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
        30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
        30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
        30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
        30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
        30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
        30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
        30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
        30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
        30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
        30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
        30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
        30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
        30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
        30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
        30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
        30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
        30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
        30'h1ffffed,
        30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,
        30'hfffff2,
        30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
        30'h7ffffe5,
        30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
        30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,
        30'h7ffff4,
        30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
        30'h7ffffea,
        30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,
        30'h3ffffee
    };

    localparam logic [4:0] CodeLen [256] = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
        5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
        5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
        5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26
    };

endpackage

### rtl/hpe_packer.sv
// Code lookup and bit packer: turns one octet into a group of finished bytes.
// Depends on hpe_pkg.
module hpe_packer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_octet,
    input  logic            i_eos,
    output logic            o_ready,
    input  logic            i_take,
    output logic            o_grp_vld,
    output hpe_pkg::t_group o_grp
);

    logic [6:0]            r_pend;
    logic [2:0]            r_pcnt;
    logic                  r_grp_vld;
    hpe_pkg::t_group       r_grp;

    logic [4:0]            len;
    logic [36:0]           acc;
    logic [5:0]            n;
    logic [2:0]            k;
    logic [2:0]            rem;
    logic [39:0]           aligned;
    logic                  do_pad;
    logic [7:0]            pad_mask;
    hpe_pkg::t_group       n_grp;
    logic [6:0]            n_pend;
    logic                  accept;

    // Append the code to the pending bits and cut the result into bytes
    always_comb begin
        len      = hpe_pkg::CodeLen[i_octet];
        acc      = ({30'd0, r_pend} << len) | {7'd0, hpe_pkg::CodeWord[i_octet]};
        n        = {3'd0, r_pcnt} + {1'b0, len};
        k        = n[5:3];
        rem      = n[2:0];
        aligned  = {3'd0, acc} << (6'd40 - n);
        do_pad   = i_eos && (rem != 3'd0);
        pad_mask = 8'hff >> rem;
        for (int i = 0; i < hpe_pkg::GroupBytes; i++) begin
            n_grp.bytes[i] = aligned[39-8*i -: 8];
            if (do_pad && (k == 3'(i))) begin
                n_grp.bytes[i] = aligned[39-8*i -: 8] | pad_mask;
            end
        end
        n_grp.cnt  = k + {2'd0, do_pad};
        n_grp.last = i_eos;
        n_grp.pad  = do_pad ? (3'd0 - rem) : 3'd0;
        n_pend     = i_eos ? 7'd0 : (acc[6:0] & ~(7'h7f << rem));
    end

    assign o_ready   = !r_grp_vld || i_take;
    assign accept    = i_valid && o_ready;
    assign o_grp_vld = r_grp_vld;
    assign o_grp     = r_grp;

    // Hold pending bits between octets; drop the group once handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 7'd0;
            r_pcnt    <= 3'd0;
            r_grp_vld <= 1'b0;
        end else if (accept) begin
            r_pend    <= n_pend;
            r_pcnt    <= i_eos ? 3'd0 : rem;
            r_grp_vld <= (n_grp.cnt != 3'd0);
        end else if (i_take) begin
            r_grp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp <= n_grp;
        end
    end

endmodule

### rtl/hpe_serializer.sv
// Output stage: sends the bytes of one group, one per transfer.
// Depends on hpe_pkg.
module hpe_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_grp_vld,
    input  hpe_pkg::t_group i_grp,
    output logic            o_take,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic [2:0]      o_pad
);

    hpe_pkg::t_group r_grp;
    logic            r_vld;
    logic [2:0]      r_idx;
    logic            final_byte;
    logic            xfer;

    assign final_byte = (r_idx == (r_grp.cnt - 3'd1));
    assign xfer       = r_vld && i_ready;
    assign o_take     = i_grp_vld && (!r_vld || (xfer && final_byte));
    assign o_valid    = r_vld;
    assign o_byte     = r_grp.bytes[r_idx];
    assign o_last     = r_grp.last && final_byte;
    assign o_pad      = o_last ? r_grp.pad : 3'd0;

    // Advance through the group; load the next one behind its final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= 3'd0;
        end else if (o_take) begin
            r_vld <= 1'b1;
            r_idx <= 3'd0;
        end else if (xfer) begin
            if (final_byte) begin
                r_vld <= 1'b0;
                r_idx <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_grp <= i_grp;
        end
    end

endmodule

### rtl/hpack_huffman_encoder.sv
// Top level of the HPACK static Huffman string encoder.
// Depends on hpe_pkg, hpe_packer and hpe_serializer.
//
// Slave channel: one string octet per transfer in tdata, tlast on the final
// octet of the string. Master channel: one coded byte per transfer, first
// code bit in the MSB; tlast flags the final byte of the string and tuser
// carries the number of one bits padded into it (zero on other bytes).
// Each octet yields 0 to 5 bytes. The packer registers them as a group at
// the edge that takes the octet; the serializer then loads that group into
// its own register at a later edge, and only then is its first byte valid.
// Octets are taken one per cycle as long as the groups drain; the master
// side sends one byte per cycle while the receiver is ready and groups are
// waiting, so sustained throughput is set by the count of coded bytes. A
// group waits in the packer while the serializer works, and the slave side
// stalls whenever the packer holds a group and the serializer is neither
// empty nor transfers the final byte of its own group in that cycle: an
// octet that codes to several bytes holds later octets back while those
// bytes go out, and a receiver stall holds them back for as long as it
// lasts. Reset clears the pending bits and empties both stages; no data is
// lost or repeated under any stall pattern.
module hpack_huffman_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] octet
    input  logic       s_axis_tlast,   // end_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] coded_byte
    output logic       m_axis_tlast,   // last_byte
    output logic [2:0] m_axis_tuser    // [2:0] pad_bits
);

    logic            grp_vld;
    logic            take;
    hpe_pkg::t_group grp;

    hpe_packer u_packer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_octet   (s_axis_tdata),
        .i_eos     (s_axis_tlast),
        .o_ready   (s_axis_tready),
        .i_take    (take),
        .o_grp_vld (grp_vld),
        .o_grp     (grp)
    );

    hpe_serializer u_serializer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_grp_vld (grp_vld),
        .i_grp     (grp),
        .o_take    (take),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_pad     (m_axis_tuser)
    );

endmodule

### tb/sv/hpack_huffman_encoder_tb.sv
// Testbench for the HPACK static Huffman string encoder.
// Drives octet strings, predicts coded bytes from the package code table,
// and checks every output byte; depends on hpe_pkg and hpack_huffman_encoder.
module hpack_huffman_encoder_tb;

    typedef struct packed {
        logic [7:0] coded;
        logic       last;
        logic [2:0] pad;
    } t_coded;

    typedef struct {
        logic [7:0] octet;
        logic       eos;
        int         n_typed;   // number of typed results, -1 uses predictor only
        t_coded     typed0;
    } t_row;

    localparam int NumRows   = 14;
    localparam int NumRandom = 230;
    localparam longint CycleLimit = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] octet
    logic       s_axis_tlast;   // end_of_string
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] coded_byte
    logic       m_axis_tlast;   // last_byte
    logic [2:0] m_axis_tuser;   // [2:0] pad_bits

    t_coded coded_queue[$];
    logic [6:0] held_bits;
    logic [2:0] held_count;
    int errors;
    int n_bytes;
    int n_strings;
    int n_pushed = 0;
    longint cycles = 0;
    bit pause_rx = 1'b0;

    hpack_huffman_encoder DUT (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Append the octet's code to the held bits and queue the finished bytes
    task automatic encode_octet(input logic [7:0] octet, input logic eos);
        logic [63:0] acc;
        int len;
        int n;
        int k;
        t_coded c;
        len = hpe_pkg::CodeLen[octet];
        acc = ({57'd0, held_bits} << len) | 64'(hpe_pkg::CodeWord[octet]);
        n = held_count + len;
        k = 0;
        while (n >= 8) begin
            c.coded = acc[n-1 -: 8];
            c.last = 1'b0;
            c.pad = 3'd0;
            coded_queue.push_back(c);
            n_pushed++;
            k++;
            n -= 8;
        end
        acc &= (64'd1 << n) - 1;
        if (eos) begin
            if (n > 0) begin
                c.coded = 8'((acc << (8 - n)) | ((64'd1 << (8 - n)) - 1));
                c.last = 1'b1;
                c.pad = 3'(8 - n);
                coded_queue.push_back(c);
                n_pushed++;
            end else if (k > 0) begin
                coded_queue[$].last = 1'b1;
            end
            held_bits = '0;
            held_count = '0;
            n_strings++;
        end else begin
            held_bits = acc[6:0];
            held_count = 3'(n);
        end
    endtask

    // Random gap: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drop valid only across a gap so back-to-back transfers keep it high
    task automatic send_octet(input logic [7:0] octet, input logic eos);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= octet;
        s_axis_tlast <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_octet(octet, eos);
    endtask

    // Receiver backpressure, with stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n || pause_rx) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 65) || (cycles % 2000 < 300);
        end
    end

    // Check each output transfer against the oldest expected byte
    always @(posedge i_clk) begin
        t_coded want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_bytes++;
            if (coded_queue.size() == 0) begin
                $display("%0t: unexpected byte %h last %b pad %0d", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                want = coded_queue.pop_front();
                if (want.coded !== m_axis_tdata || want.last !== m_axis_tlast ||
                    want.pad !== m_axis_tuser) begin
                    $display("%0t: expected byte %h last %b pad %0d, got %h last %b pad %0d",
                             $time, want.coded, want.last, want.pad,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (coded_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    t_row rows[NumRows];

    initial begin
        int len;
        errors = 0;
        n_bytes = 0;
        n_strings = 0;
        held_bits = '0;
        held_count = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;

        // Directed strings: shortest codes, longest codes, boundaries
        rows[0]  = '{8'h30, 1'b1, 1, '{8'h07, 1'b1, 3'd3}};  // '0' alone, padded
        rows[1]  = '{8'h0a, 1'b1, -1, '0};                   // 30-bit code alone
        rows[2]  = '{8'h30, 1'b0, 0, '0};                    // five bits, no byte
        rows[3]  = '{8'h30, 1'b0, 1, '{8'h00, 1'b0, 3'd0}};
        rows[4]  = '{8'h30, 1'b0, 0, '0};
        rows[5]  = '{8'h30, 1'b1, -1, '0};                   // full byte, then padded
        rows[6]  = '{8'hff, 1'b0, -1, '0};
        rows[7]  = '{8'h00, 1'b0, -1, '0};
        rows[8]  = '{8'h0d, 1'b0, -1, '0};
        rows[9]  = '{8'h16, 1'b1, -1, '0};
        rows[10] = '{8'h26, 1'b1, 1, '{8'hf8, 1'b1, 3'd0}};  // 8-bit code, no pad
        rows[11] = '{8'h80, 1'b0, -1, '0};
        rows[12] = '{8'h7f, 1'b0, -1, '0};
        rows[13] = '{8'h55, 1'b1, -1, '0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NumRows; i++) begin
            int pushed_start;
            pushed_start = n_pushed;
            send_octet(rows[i].octet, rows[i].eos);
            if (rows[i].n_typed >= 0) begin
                if (n_pushed - pushed_start != rows[i].n_typed ||
                    (rows[i].n_typed == 1 && coded_queue[$] != rows[i].typed0)) begin
                    $display("%0t: row %0d expected %0d bytes (%h), predicted %0d",
                             $time, i, rows[i].n_typed, rows[i].typed0,
                             n_pushed - pushed_start);
                    errors++;
                end
            end
        end

        // Hold the sender until every byte so far is out
        wait_drained();

        // Random strings: mostly text, some high or control octets
        len = 0;
        for (int i = 0; i < NumRandom; i++) begin
            logic [7:0] oc;
            logic eos;
            int r;
            r = $urandom_range(0, 9);
            if (r < 6) oc = 8'($urandom_range(32, 126));
            else if (r < 8) oc = 8'($urandom_range(128, 255));
            else oc = 8'($urandom_range(0, 31));
            if (len == 0) len = $urandom_range(1, 12);
            len--;
            eos = (len == 0) || (i == NumRandom - 1);
            if (eos) len = 0;
            if (i == NumRandom / 2) pause_rx = 1'b1;
            send_octet(oc, eos);
            if (i == NumRandom / 2) begin
                wait_drained();
                pause_rx = 1'b0;
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d octets in %0d strings, checked %0d coded bytes.",
                 NumRows + NumRandom, n_strings, n_bytes);
        if (errors == 0 && coded_queue.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### sim.f
rtl/hpe_pkg.sv
rtl/hpe_packer.sv
rtl/hpe_serializer.sv
rtl/hpack_huffman_encoder.sv
tb/sv/hpack_huffman_encoder_tb.sv
